FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/ioa_pkg.sv
// Shared types and constants for the interval overlap admission block.
// No dependencies; imported by all ioa modules and the top level.
package ioa_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int TIME_BITS_DEF  = 32;
	localparam int DELTA_W        = 6;
	localparam int SUM_W          = 8;
	localparam int MAXOV_W        = 4;

	localparam logic [MAXOV_W-1:0] MAX_OVERLAP_RST = 4'd2;

	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	localparam delta_t DELTA_PLUS  = 6'sd1;
	localparam delta_t DELTA_MINUS = -6'sd1;

	// result codes
	typedef enum logic [1:0] {
		ST_BOOKED   = 2'd0,
		ST_OVERLAP  = 2'd1,
		ST_FULL     = 2'd2,
		ST_REVERSED = 2'd3
	} status_t;

	// flags and sums from the shared compare/add unit
	typedef struct packed {
		logic   t_gt_s;
		logic   t_eq_s;
		logic   t_gt_e;
		logic   t_eq_e;
		logic   s_fail;
		logic   e_fail;
		logic   entry_fail;
		delta_t new_delta;
		sum_t   next_acc;
	} step_res_t;

endpackage

FILE: rtl/interval_overlap_admission.sv
// Top level of the interval overlap admission block: sequencer, result
// register and config register. Depends on ioa_pkg, ioa_point_mem,
// ioa_step_unit and assert_macros.svh.
//
//  channel | signals                          | direction | transfer
//  --------+----------------------------------+-----------+--------------------
//  in      | in_valid in_ready start/end_time | to block  | valid & ready
//  out     | out_valid out_ready booked status| from block| valid & ready
//  cfg     | cfg_wr_en cfg_wr_data            | to block  | write enable, no wait
//
// An empty or reversed interval goes from CHECK straight to RESP, with no scan.
// A rejected request takes one scan pass; a booked one also takes a write
// pass that rebuilds the table into the other bank, at most one write a cycle.
// No clearing pass after reset; in_ready is low while a request is in work,
// and a finished result waits in RESP while an earlier result is still held
// with out_ready low.
`include "assert_macros.svh"

module interval_overlap_admission
	import ioa_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_BITS-1:0] start_time,
	input  logic [TIME_BITS-1:0] end_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 booked,
	output logic [1:0]           status,
	input  logic                 cfg_wr_en,
	input  logic [MAXOV_W-1:0]   cfg_wr_data
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CHECK  = 8'b0000_0010,
		ST_LOAD   = 8'b0000_0100,
		ST_SCAN   = 8'b0000_1000,
		ST_DECIDE = 8'b0001_0000,
		ST_CLOAD  = 8'b0010_0000,
		ST_COMMIT = 8'b0100_0000,
		ST_RESP   = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [TIME_BITS-1:0] s_q;
	logic [TIME_BITS-1:0] e_q;
	logic [MAXOV_W-1:0]   max_overlap_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     ridx_q;
	logic [CNT_W-1:0]     widx_q;
	logic                 bank_q;
	sum_t                 acc_q;
	logic                 has_s_q;
	logic                 has_e_q;
	logic                 s_done_q;
	logic                 e_done_q;
	logic                 fail_q;
	logic                 pend_booked_q;
	status_t              pend_status_q;
	logic                 out_valid_q;
	logic                 booked_q;
	status_t              status_q;

	logic [TIME_BITS-1:0] rd_time;
	delta_t               rd_delta;
	logic [TIME_BITS-1:0] unit_t;
	step_res_t            u;

	logic                 avail;
	logic                 ins_s;
	logic                 ins_e;
	logic                 keep;
	logic                 advance;
	logic [CNT_W-1:0]     ridx_next;
	logic [IDX_W-1:0]     rd_idx;
	logic                 mem_we;
	logic [IDX_W:0]       mem_waddr;
	logic [IDX_W:0]       mem_raddr;
	logic [TIME_BITS-1:0] mem_wtime;
	delta_t               mem_wdelta;
	logic [1:0]           fresh;
	logic                 too_full;

	// point table
	ioa_point_mem #(
		.MAX_POINTS (MAX_POINTS),
		.TIME_BITS  (TIME_BITS)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wtime  (mem_wtime),
		.wdelta (mem_wdelta),
		.raddr  (mem_raddr),
		.rtime  (rd_time),
		.rdelta (rd_delta)
	);

	// shared compare/add unit; in CHECK it orders start against end
	assign unit_t = (state_q == ST_CHECK) ? s_q : rd_time;

	ioa_step_unit #(
		.TIME_BITS (TIME_BITS)
	) u_step (
		.t           (unit_t),
		.d           (rd_delta),
		.s           (s_q),
		.e           (e_q),
		.acc         (acc_q),
		.max_overlap (max_overlap_q),
		.res         (u)
	);

	// commit pass selection: fresh start, fresh end, or the stored entry
	assign avail = ridx_q < count_q;
	assign ins_s = !s_done_q && (!avail || u.t_gt_s);
	assign ins_e = !ins_s && !e_done_q && (!avail || u.t_gt_e);
	assign keep  = !ins_s && !ins_e && avail;

	assign advance = ((state_q == ST_SCAN) && avail) || ((state_q == ST_COMMIT) && keep);

	// read address: hold the current entry unless it is consumed
	assign ridx_next = ridx_q + CNT_W'(1);
	always_comb begin
		if ((state_q == ST_LOAD) || (state_q == ST_CLOAD)) begin
			rd_idx = '0;
		end else if (advance) begin
			rd_idx = ridx_next[IDX_W-1:0];
		end else begin
			rd_idx = ridx_q[IDX_W-1:0];
		end
	end
	assign mem_raddr = {bank_q, rd_idx};

	// write side goes to the other bank
	assign mem_we = (state_q == ST_COMMIT) &&
		(ins_s || ins_e || (keep && (u.new_delta != '0)));
	assign mem_waddr  = {~bank_q, widx_q[IDX_W-1:0]};
	assign mem_wtime  = ins_s ? s_q : (ins_e ? e_q : rd_time);
	assign mem_wdelta = ins_s ? DELTA_PLUS : (ins_e ? DELTA_MINUS : u.new_delta);

	// fill check before any change
	assign fresh    = {1'b0, !has_s_q} + {1'b0, !has_e_q};
	assign too_full = ({1'b0, count_q} + (CNT_W+1)'(fresh)) > (CNT_W+1)'(MAX_POINTS);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign booked    = booked_q;
	assign status    = status_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_overlap_q <= MAX_OVERLAP_RST;
		end else if (cfg_wr_en) begin
			max_overlap_q <= cfg_wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESP) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESP) && (!out_valid_q || out_ready)) begin
			booked_q <= pend_booked_q;
			status_q <= pend_status_q;
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			bank_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (u.t_gt_e || u.t_eq_e) begin
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (!avail) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (too_full || fail_q) begin
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_CLOAD;
					end
				end
				ST_CLOAD: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					if (!ins_s && !ins_e && !keep) begin
						count_q <= widx_q;
						bank_q  <= ~bank_q;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sequencer datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				s_q <= start_time;
				e_q <= end_time;
			end
			ST_CHECK: begin
				acc_q    <= '0;
				has_s_q  <= 1'b0;
				has_e_q  <= 1'b0;
				s_done_q <= 1'b0;
				e_done_q <= 1'b0;
				fail_q   <= 1'b0;
				if (u.t_gt_e) begin
					pend_booked_q <= 1'b0;
					pend_status_q <= ST_REVERSED;
				end else begin
					pend_booked_q <= 1'b1;
					pend_status_q <= ST_BOOKED;
				end
			end
			ST_LOAD, ST_CLOAD: begin
				ridx_q <= '0;
				widx_q <= '0;
			end
			ST_SCAN: begin
				if (avail) begin
					// fresh start or end point passed before this entry
					if ((!s_done_q && u.t_gt_s && u.s_fail) ||
						(!e_done_q && u.t_gt_e && u.e_fail) || u.entry_fail) begin
						fail_q <= 1'b1;
					end
					if (u.t_gt_s || u.t_eq_s) begin
						s_done_q <= 1'b1;
					end
					if (u.t_gt_e || u.t_eq_e) begin
						e_done_q <= 1'b1;
					end
					if (u.t_eq_s) begin
						has_s_q <= 1'b1;
					end
					if (u.t_eq_e) begin
						has_e_q <= 1'b1;
					end
					acc_q  <= u.next_acc;
					ridx_q <= ridx_next;
				end else begin
					// fresh points after the last stored entry
					if ((!s_done_q && u.s_fail) || (!e_done_q && u.e_fail)) begin
						fail_q <= 1'b1;
					end
				end
			end
			ST_DECIDE: begin
				s_done_q <= has_s_q;
				e_done_q <= has_e_q;
				if (too_full) begin
					pend_booked_q <= 1'b0;
					pend_status_q <= ST_FULL;
				end else if (fail_q) begin
					pend_booked_q <= 1'b0;
					pend_status_q <= ST_OVERLAP;
				end else begin
					pend_booked_q <= 1'b1;
					pend_status_q <= ST_BOOKED;
				end
			end
			ST_COMMIT: begin
				if (ins_s) begin
					s_done_q <= 1'b1;
				end
				if (ins_e) begin
					e_done_q <= 1'b1;
				end
				if (keep) begin
					ridx_q <= ridx_next;
				end
				if (mem_we) begin
					widx_q <= widx_q + CNT_W'(1);
				end
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// checks
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_POINTS))
	`ASSERT_IMPLIES(a_write_in_range, clk, arst_n, mem_we, widx_q < CNT_W'(MAX_POINTS))
	`ASSERT_NEXT(a_result_from_resp, clk, arst_n, !out_valid_q && state_q != ST_RESP, !out_valid_q)
	`ASSERT_IMPLIES(a_booked_status, clk, arst_n, out_valid_q, booked_q == (status_q == ST_BOOKED))

endmodule

FILE: rtl/ioa_point_mem.sv
// Boundary point storage: two banks of time/delta entries, one write and
// one registered read per cycle. Depends on ioa_pkg.
module ioa_point_mem
	import ioa_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(MAX_POINTS):0]   waddr,
	input  logic [TIME_BITS-1:0]          wtime,
	input  delta_t                        wdelta,
	input  logic [$clog2(MAX_POINTS):0]   raddr,
	output logic [TIME_BITS-1:0]          rtime,
	output delta_t                        rdelta
);

	// bank bit on top of a power-of-two bank, so every address is in range
	localparam int DEPTH = 2 ** ($clog2(MAX_POINTS) + 1);

	logic [TIME_BITS-1:0] time_mem [DEPTH];
	delta_t               delta_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[waddr]  <= wtime;
			delta_mem[waddr] <= wdelta;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rtime  <= time_mem[raddr];
		rdelta <= delta_mem[raddr];
	end

endmodule

FILE: rtl/ioa_step_unit.sv
// Shared compare/add unit: orders one entry time against the request bounds
// and forms the running sum and limit checks. Depends on ioa_pkg.
module ioa_step_unit
	import ioa_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic [TIME_BITS-1:0] t,
	input  delta_t               d,
	input  logic [TIME_BITS-1:0] s,
	input  logic [TIME_BITS-1:0] e,
	input  sum_t                 acc,
	input  logic [MAXOV_W-1:0]   max_overlap,
	output step_res_t            res
);

	logic   ge_s;
	logic   ge_e;
	sum_t   lim;
	sum_t   entry_sum;
	logic signed [DELTA_W:0] nd_wide;

	// time compares
	assign res.t_gt_s = t > s;
	assign res.t_eq_s = t == s;
	assign res.t_gt_e = t > e;
	assign res.t_eq_e = t == e;

	assign ge_s = res.t_gt_s | res.t_eq_s;
	assign ge_e = res.t_gt_e | res.t_eq_e;
	assign lim  = sum_t'(max_overlap);

	// running sum with the request's own +1/-1 folded in
	assign res.next_acc = acc + sum_t'(d);
	assign entry_sum    = res.next_acc + sum_t'(ge_s) - sum_t'(ge_e);

	assign res.entry_fail = entry_sum > lim;
	assign res.s_fail     = (acc + sum_t'(1)) > lim;
	assign res.e_fail     = acc > lim;

	// delta of this entry once the request is merged
	assign nd_wide       = (DELTA_W+1)'(d) + (DELTA_W+1)'(res.t_eq_s) - (DELTA_W+1)'(res.t_eq_e);
	assign res.new_delta = nd_wide[DELTA_W-1:0];

endmodule
